// ----- rtl/fmc_pkg.sv -----
// Shared types, register offsets and float helpers for the float math coprocessor.
// Used by the round unit, the divider, the top level and the testbench; depends on nothing else.
package fmc_pkg;

  // Access direction of one bus transaction
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Register byte offsets
  localparam logic [4:0] OFF_CTRL0   = 5'd0;
  localparam logic [4:0] OFF_CTRL1   = 5'd1;
  localparam logic [4:0] OFF_ST_MUL  = 5'd4;
  localparam logic [4:0] OFF_ST_DIV  = 5'd5;
  localparam logic [4:0] OFF_ST_ADD  = 5'd6;
  localparam logic [4:0] OFF_ST_CONV = 5'd7;
  localparam logic [2:0] GRP_OPA     = 3'd2;  // offsets 8..11
  localparam logic [2:0] GRP_OPB     = 3'd3;  // offsets 12..15
  localparam logic [2:0] GRP_FLT     = 3'd4;  // offsets 16..19
  localparam logic [2:0] GRP_FIX     = 3'd5;  // offsets 20..23

  // Output select codes of ctrl1
  localparam logic [1:0] OSEL_MUL = 2'd0;
  localparam logic [1:0] OSEL_DIV = 2'd1;
  localparam logic [1:0] OSEL_SUM = 2'd2;
  localparam logic [1:0] OSEL_ONE = 2'd3;

  // Adder input codes of ctrl0
  localparam logic [1:0] ASEL_A   = 2'd0;
  localparam logic [1:0] ASEL_B   = 2'd1;
  localparam logic [1:0] ASEL_MUL = 2'd2;
  localparam logic [1:0] ASEL_DIV = 2'd3;

  // Status bits
  localparam logic [7:0] ST_NAN  = 8'h01;
  localparam logic [7:0] ST_INF  = 8'h02;
  localparam logic [7:0] ST_DEN  = 8'h04;
  localparam logic [7:0] ST_ZERO = 8'h08;
  localparam logic [7:0] ST_DBZ  = 8'h10;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] FIX_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] FIX_MIN   = 32'h8000_0000;

  // Quotient bits produced by the divider
  localparam int DIV_STEPS = 29;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FIN,
    CLS_INF,
    CLS_NAN
  } fcls_t;

  // Unpacked single: value = 1.mant[22:0] * 2^exp for finite numbers
  typedef struct packed {
    logic               sign;
    fcls_t              cls;
    logic signed [10:0] exp;
    logic [23:0]        mant;
  } unp_t;

  // Request to the shared normalize/round unit; sig bit 31 weighs 2^exp_top
  typedef struct packed {
    logic               sign;
    logic signed [10:0] exp_top;
    logic [31:0]        sig;
    logic               sticky;
  } rnd_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CVA,
    ST_CVB,
    ST_MUL,
    ST_MULR,
    ST_DIVS,
    ST_DIVW,
    ST_DIVR,
    ST_ADD,
    ST_ADDR,
    ST_OUT
  } state_t;

  // Split a single into class, sign, exponent and normalized significand
  function automatic unp_t unpack(input logic [31:0] u);
    unp_t       r;
    logic [4:0] lz;
    r.sign = u[31];
    r.cls  = CLS_FIN;
    r.exp  = '0;
    r.mant = '0;
    lz     = '0;
    if (u[30:23] == 8'hFF) begin
      r.cls = (u[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
    end else if (u[30:23] == 8'h00) begin
      if (u[22:0] == 23'd0) begin
        r.cls = CLS_ZERO;
      end else begin
        for (int i = 0; i < 23; i++) begin
          if (u[i]) lz = 5'(22 - i);
        end
        r.mant = {1'b0, u[22:0]} << (lz + 5'd1);
        r.exp  = -11'sd127 - $signed({6'b0, lz});
      end
    end else begin
      r.mant = {1'b1, u[22:0]};
      r.exp  = $signed({3'b0, u[30:23]}) - 11'sd127;
    end
    return r;
  endfunction

  // Status byte of a result
  function automatic logic [7:0] status_of(input logic [31:0] u);
    logic [7:0] r;
    r = '0;
    if (u[30:23] == 8'hFF && u[22:0] != 23'd0) r = r | ST_NAN;
    if (u[30:23] == 8'hFF && u[22:0] == 23'd0) r = r | ST_INF;
    if (u[30:0] == 31'd0) r = r | ST_ZERO;
    else if (u[30:23] == 8'h00 || u[30:23] == 8'hFF) r = r | ST_DEN;
    return r;
  endfunction

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = w[7:0];
      2'd1:    r = w[15:8];
      2'd2:    r = w[23:16];
      default: r = w[31:24];
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/fmc_round.sv -----
// Shared normalize and round-to-nearest-even unit, packing to IEEE single.
// Handles subnormal and overflowing results; depends on fmc_pkg.
module fmc_round (
  input  fmc_pkg::rnd_req_t req,
  output logic [31:0]       res_bits
);
  import fmc_pkg::*;

  logic [4:0]         lz;
  logic [31:0]        n;
  logic signed [10:0] e;
  logic signed [10:0] be;
  logic signed [10:0] sh;
  logic [31:0]        m;
  logic [7:0]         ef;
  logic               lost;
  logic               rinc;
  logic [30:0]        body;

  always_comb begin
    // find leading one and normalize it to bit 31
    lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (req.sig[i]) lz = 5'(31 - i);
    end
    n  = req.sig << lz;
    e  = req.exp_top - $signed({6'b0, lz});
    be = e + 11'sd127;
    sh = 11'sd1 - be;
    // denormalize when below the normal range
    if (be >= 11'sd1) begin
      m    = n;
      ef   = be[7:0];
      lost = 1'b0;
    end else if (sh >= 11'sd32) begin
      m    = '0;
      ef   = '0;
      lost = |n;
    end else begin
      m    = n >> sh[4:0];
      ef   = '0;
      lost = |(n & ~(32'hFFFF_FFFF << sh[4:0]));
    end
    // round half to even; carry may step exponent or reach infinity
    rinc = m[7] & (m[8] | (|m[6:0]) | req.sticky | lost);
    body = {ef, m[30:8]} + 31'(rinc);
    if (be >= 11'sd255) res_bits = {req.sign, 8'hFF, 23'd0};
    else                res_bits = {req.sign, body};
  end

endmodule

// ----- rtl/fmc_divider.sv -----
// Restoring significand divider, one quotient bit per cycle.
// Depends on fmc_pkg for the step count.
module fmc_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] dividend,
  input  logic [23:0] divisor,
  output logic        done,
  output logic [28:0] quo,
  output logic        rem_nz
);
  import fmc_pkg::*;

  logic              run_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [24:0]       rem_r;
  logic [23:0]       dvs_r;
  logic [28:0]       q_r;
  logic [25:0]       diff;
  logic              ge;
  logic [24:0]       rem_sel;

  // trial subtract
  always_comb begin
    diff    = {1'b0, rem_r} - {2'b0, dvs_r};
    ge      = ~diff[25];
    rem_sel = ge ? diff[24:0] : rem_r;
  end

  // advance the control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      dvs_r <= divisor;
    end else if (run_r) begin
      rem_r <= {rem_sel[23:0], 1'b0};
      q_r   <= {q_r[27:0], ge};
    end
  end

  assign done   = done_r;
  assign quo    = q_r;
  assign rem_nz = (rem_r != 25'd0);

endmodule

// ----- rtl/float_math_coprocessor.sv -----
// Top level of the float math coprocessor: register file, sequencer and datapath.
// Depends on fmc_pkg, fmc_round and fmc_divider.
//
// Usage: one byte-wide transaction per start pulse, taken when start is high and
// busy is low. in_mode selects write or read, in_offset the register byte,
// in_write_data the byte written. Every transaction returns exactly one byte on
// out_read_data, marked by a one-cycle out_valid strobe (zero for writes,
// operand reads and unmapped offsets).
// Writes and reads of ctrl0, ctrl1 and unmapped offsets answer in the cycle after
// acceptance and leave busy low, so one such transaction fits in every cycle.
// Reads of status and output bytes run the sequencer: operand conversion, product,
// quotient and sum all pass through one shared normalize/round unit, and the
// quotient comes from a restoring divider that yields one bit a cycle; the
// divider is skipped when the quotient is a special case. busy is high until
// the strobe.
// The receiver cannot stall the strobe; it must take the byte when shown.
// Synchronous reset clears ctrl0, ctrl1, the operands and the strobe to zero and returns to idle.
module float_math_coprocessor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_mode,
  input  logic [4:0] in_offset,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  output logic [7:0] out_read_data
);
  import fmc_pkg::*;

  state_t      state_r, state_nxt;
  logic [7:0]  ctrl0_r, ctrl1_r;
  logic [31:0] opa_r, opb_r;
  logic [4:0]  off_r;
  logic [31:0] a_val_r, b_val_r, mul_r, quo_r, sum_r;
  logic [47:0] prod_r;
  logic [27:0] addr_r;
  logic signed [10:0] rexp_r;
  logic        rsign_r;
  logic        spec_r;
  logic [31:0] spec_bits_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;

  logic        accept;
  logic        calc_off;
  unp_t        a_u, b_u;
  rnd_req_t    rreq;
  logic [31:0] rnd_bits;
  logic [31:0] fx_raw, fx_mag;
  logic        div_start, div_done, div_rem_nz;
  logic [28:0] div_q;

  assign accept   = start & ~busy;
  assign calc_off = (in_offset[4:2] == 3'b001) || (in_offset[4:3] == 2'b10);
  assign a_u      = unpack(a_val_r);
  assign b_u      = unpack(b_val_r);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_mode == MODE_READ && calc_off) state_nxt = ST_CVA;
      ST_CVA:  state_nxt = ST_CVB;
      ST_CVB:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_MULR;
      ST_MULR: state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = div_start ? ST_DIVW : ST_DIVR;
      ST_DIVW: if (div_done) state_nxt = ST_DIVR;
      ST_DIVR: state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- fixed operand conversion ----------------
  always_comb begin
    fx_raw = (state_r == ST_CVA) ? opa_r : opb_r;
    fx_mag = fx_raw[31] ? (~fx_raw + 32'd1) : fx_raw;
  end

  // ---------------- multiply special cases ----------------
  logic        mul_nan, mul_inf, mul_zero, mr_sign;
  logic [47:0] prod_nxt;
  always_comb begin
    mr_sign  = a_u.sign ^ b_u.sign;
    mul_nan  = (a_u.cls == CLS_NAN) || (b_u.cls == CLS_NAN) ||
               (a_u.cls == CLS_INF && b_u.cls == CLS_ZERO) ||
               (a_u.cls == CLS_ZERO && b_u.cls == CLS_INF);
    mul_inf  = (a_u.cls == CLS_INF) || (b_u.cls == CLS_INF);
    mul_zero = (a_u.cls == CLS_ZERO) || (b_u.cls == CLS_ZERO);
    prod_nxt = a_u.mant * b_u.mant;
  end

  // ---------------- divide special cases ----------------
  logic        div_spec;
  logic [31:0] div_bits;
  always_comb begin
    div_spec = 1'b1;
    div_bits = CANON_NAN;
    if (b_u.cls == CLS_ZERO) begin
      if (a_u.cls == CLS_NAN || a_u.cls == CLS_ZERO) div_bits = CANON_NAN;
      else div_bits = {mr_sign, 8'hFF, 23'd0};
    end else if (a_u.cls == CLS_NAN || b_u.cls == CLS_NAN) begin
      div_bits = CANON_NAN;
    end else if (a_u.cls == CLS_INF && b_u.cls == CLS_INF) begin
      div_bits = CANON_NAN;
    end else if (a_u.cls == CLS_INF) begin
      div_bits = {mr_sign, 8'hFF, 23'd0};
    end else if (b_u.cls == CLS_INF || a_u.cls == CLS_ZERO) begin
      div_bits = {mr_sign, 31'd0};
    end else begin
      div_spec = 1'b0;
    end
  end

  // ---------------- adder alignment ----------------
  function automatic logic [31:0] pick(input logic [1:0] code, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] p,
                                       input logic [31:0] q);
    logic [31:0] r;
    case (code)
      ASEL_A:   r = a;
      ASEL_B:   r = b;
      ASEL_MUL: r = p;
      default:  r = q;
    endcase
    return r;
  endfunction

  logic [31:0]        xb, yb0, yb;
  unp_t               x_u, y_u, big, sml;
  logic signed [10:0] d;
  logic [27:0]        big28, sm28, sh28, r28;
  logic               st_bit, eff_sub, add_spec;
  logic [31:0]        add_bits;
  always_comb begin
    xb  = pick(ctrl0_r[5:4], a_val_r, b_val_r, mul_r, quo_r);
    yb0 = pick(ctrl0_r[7:6], a_val_r, b_val_r, mul_r, quo_r);
    yb  = {yb0[31] ^ ~ctrl0_r[3], yb0[30:0]};
    x_u = unpack(xb);
    y_u = unpack(yb);
    if ((y_u.exp > x_u.exp) || (y_u.exp == x_u.exp && y_u.mant > x_u.mant)) begin
      big = y_u;
      sml = x_u;
    end else begin
      big = x_u;
      sml = y_u;
    end
    d     = big.exp - sml.exp;
    big28 = {1'b0, big.mant, 3'b0};
    sm28  = {1'b0, sml.mant, 3'b0};
    if (d >= 11'sd28) begin
      sh28   = '0;
      st_bit = 1'b1;
    end else begin
      sh28   = sm28 >> d[4:0];
      st_bit = |(sm28 & ~(28'hFFF_FFFF << d[4:0]));
    end
    eff_sub = x_u.sign ^ y_u.sign;
    r28     = eff_sub ? (big28 - (sh28 | 28'(st_bit))) : (big28 + (sh28 | 28'(st_bit)));
    // exceptional operands and exact cancellation
    add_spec = 1'b1;
    add_bits = CANON_NAN;
    if (x_u.cls == CLS_NAN || y_u.cls == CLS_NAN) begin
      add_bits = CANON_NAN;
    end else if (x_u.cls == CLS_INF && y_u.cls == CLS_INF) begin
      add_bits = eff_sub ? CANON_NAN : xb;
    end else if (x_u.cls == CLS_INF) begin
      add_bits = xb;
    end else if (y_u.cls == CLS_INF) begin
      add_bits = yb;
    end else if (x_u.cls == CLS_ZERO && y_u.cls == CLS_ZERO) begin
      add_bits = {x_u.sign & y_u.sign, 31'd0};
    end else if (x_u.cls == CLS_ZERO) begin
      add_bits = yb;
    end else if (y_u.cls == CLS_ZERO) begin
      add_bits = xb;
    end else if (r28 == 28'd0) begin
      add_bits = 32'd0;
    end else begin
      add_spec = 1'b0;
    end
  end

  // ---------------- round unit request ----------------
  always_comb begin
    div_start = (state_r == ST_DIVS) && !div_spec;
    rreq      = '0;
    unique case (state_r)
      ST_CVA, ST_CVB: begin
        rreq.sign    = fx_raw[31];
        rreq.exp_top = 11'sd19;
        rreq.sig     = fx_mag;
      end
      ST_MULR: begin
        rreq.sign    = rsign_r;
        rreq.exp_top = rexp_r;
        rreq.sig     = prod_r[47:16];
        rreq.sticky  = |prod_r[15:0];
      end
      ST_DIVR: begin
        rreq.sign    = rsign_r;
        rreq.exp_top = rexp_r;
        rreq.sig     = {div_q, 3'b0};
        rreq.sticky  = div_rem_nz;
      end
      ST_ADDR: begin
        rreq.sign    = rsign_r;
        rreq.exp_top = rexp_r;
        rreq.sig     = {addr_r, 4'b0};
      end
      default: rreq = '0;
    endcase
  end

  fmc_round u_round (
    .req      (rreq),
    .res_bits (rnd_bits)
  );

  fmc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (a_u.mant),
    .divisor  (b_u.mant),
    .done     (div_done),
    .quo      (div_q),
    .rem_nz   (div_rem_nz)
  );

  // ---------------- output conversion ----------------
  logic [31:0]        res_bits, fix_bits, fix_mag;
  unp_t               r_u;
  logic signed [10:0] fexp;
  logic [7:0]         conv_st, calc_byte;
  always_comb begin
    case (ctrl1_r[1:0])
      OSEL_MUL: res_bits = mul_r;
      OSEL_DIV: res_bits = quo_r;
      OSEL_SUM: res_bits = sum_r;
      default:  res_bits = ONE_BITS;
    endcase
    r_u     = unpack(res_bits);
    fexp    = r_u.exp + 11'sd12;
    fix_mag = '0;
    if (fexp >= 11'sd23) fix_mag = {8'b0, r_u.mant} << 5'(fexp - 11'sd23);
    else if (fexp >= 11'sd0) fix_mag = {8'b0, r_u.mant} >> 5'(11'sd23 - fexp);
    // fixed value, truncated, saturating outside int32
    if (r_u.cls == CLS_NAN || r_u.cls == CLS_ZERO) fix_bits = '0;
    else if (r_u.cls == CLS_INF || fexp >= 11'sd31) fix_bits = r_u.sign ? FIX_MIN : FIX_MAX;
    else fix_bits = r_u.sign ? (~fix_mag + 32'd1) : fix_mag;
    // conversion flags
    conv_st = '0;
    if (r_u.cls == CLS_ZERO) conv_st = ST_ZERO;
    else if (r_u.cls == CLS_INF) conv_st = ST_INF;
    else if (r_u.cls == CLS_FIN) begin
      if (!r_u.sign && (r_u.exp >= 11'sd19 ||
                        (r_u.exp == 11'sd18 && r_u.mant > 24'd16777184)))
        conv_st = ST_INF;
      else if (r_u.sign && (r_u.exp > 11'sd19 ||
                            (r_u.exp == 11'sd19 && r_u.mant != 24'h80_0000)))
        conv_st = ST_INF;
      else if (r_u.exp < -11'sd12)
        conv_st = ST_DEN;
    end
    // byte select
    calc_byte = '0;
    if (off_r == OFF_ST_MUL) calc_byte = status_of(mul_r);
    else if (off_r == OFF_ST_DIV)
      calc_byte = status_of(quo_r) | ((b_u.cls == CLS_ZERO) ? ST_DBZ : 8'h00);
    else if (off_r == OFF_ST_ADD) calc_byte = status_of(sum_r);
    else if (off_r == OFF_ST_CONV) calc_byte = conv_st;
    else if (off_r[4:2] == GRP_FLT) calc_byte = byte_of(res_bits, off_r[1:0]);
    else if (off_r[4:2] == GRP_FIX) calc_byte = byte_of(fix_bits, off_r[1:0]);
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ctrl0_r     <= '0;
      ctrl1_r     <= '0;
      opa_r       <= '0;
      opb_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && !(in_mode == MODE_READ && calc_off)) ||
                     (state_r == ST_OUT);
      // store written bytes
      if (accept && in_mode == MODE_WRITE) begin
        if (in_offset == OFF_CTRL0) ctrl0_r <= in_write_data;
        if (in_offset == OFF_CTRL1) ctrl1_r <= in_write_data;
        if (in_offset[4:2] == GRP_OPA) begin
          case (in_offset[1:0])
            2'd0:    opa_r[7:0]   <= in_write_data;
            2'd1:    opa_r[15:8]  <= in_write_data;
            2'd2:    opa_r[23:16] <= in_write_data;
            default: opa_r[31:24] <= in_write_data;
          endcase
        end
        if (in_offset[4:2] == GRP_OPB) begin
          case (in_offset[1:0])
            2'd0:    opb_r[7:0]   <= in_write_data;
            2'd1:    opb_r[15:8]  <= in_write_data;
            2'd2:    opb_r[23:16] <= in_write_data;
            default: opb_r[31:24] <= in_write_data;
          endcase
        end
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      off_r <= in_offset;
      if (in_mode == MODE_READ && in_offset == OFF_CTRL0) out_data_r <= ctrl0_r;
      else if (in_mode == MODE_READ && in_offset == OFF_CTRL1) out_data_r <= ctrl1_r;
      else out_data_r <= 8'h00;
    end
    case (state_r)
      ST_CVA: begin
        if (!ctrl0_r[0]) a_val_r <= opa_r;
        else if (opa_r == 32'd0) a_val_r <= 32'd0;
        else a_val_r <= rnd_bits;
      end
      ST_CVB: begin
        if (!ctrl0_r[1]) b_val_r <= opb_r;
        else if (opb_r == 32'd0) b_val_r <= 32'd0;
        else b_val_r <= rnd_bits;
      end
      ST_MUL: begin
        spec_r      <= mul_nan | mul_inf | mul_zero;
        spec_bits_r <= mul_nan ? CANON_NAN :
                       mul_inf ? {mr_sign, 8'hFF, 23'd0} : {mr_sign, 31'd0};
        prod_r      <= prod_nxt;
        rexp_r      <= a_u.exp + b_u.exp + 11'sd1;
        rsign_r     <= mr_sign;
      end
      ST_MULR: mul_r <= spec_r ? spec_bits_r : rnd_bits;
      ST_DIVS: begin
        spec_r      <= div_spec;
        spec_bits_r <= div_bits;
        rexp_r      <= a_u.exp - b_u.exp;
        rsign_r     <= mr_sign;
      end
      ST_DIVR: quo_r <= spec_r ? spec_bits_r : rnd_bits;
      ST_ADD: begin
        spec_r      <= add_spec;
        spec_bits_r <= add_bits;
        addr_r      <= r28;
        rexp_r      <= big.exp + 11'sd1;
        rsign_r     <= big.sign;
      end
      ST_ADDR: sum_r <= spec_r ? spec_bits_r : rnd_bits;
      ST_OUT:  out_data_r <= calc_byte;
      default: ;
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

// ----- rtl/fmc_checker.sv -----
// Port-level checks of the float math coprocessor handshake and sequencing.
// Bound to float_math_coprocessor; uses only its ports.
module fmc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every accepted transaction either strobes next or starts a computation
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction neither answered nor started");

  // no strobe while the sequencer runs
  a_quiet_busy: assert property (@(posedge clk) busy |-> !out_valid)
    else $error("strobe while busy");

  // end of a computation delivers its byte
  a_done_strobe: assert property (@(posedge clk)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("computation ended without a strobe");

  // reset leaves the block idle and quiet
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

endmodule

bind float_math_coprocessor fmc_checker u_fmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- test/tb_top.sv -----
// Self-checking testbench of the float math coprocessor: directed table, then random
// register traffic checked by a bit-exact single-precision predictor. Depends on fmc_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fmc_pkg::*;

  localparam int ITEM_TARGET = 550;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_mode = MODE_WRITE;
  logic [4:0] in_offset = '0;
  logic [7:0] in_write_data = '0;
  logic       out_valid;
  logic [7:0] out_read_data;

  // Shadow registers of the block
  logic [7:0]  sh_ictl, sh_octl;
  logic [31:0] sh_opa, sh_opb;

  logic [7:0] exp_bytes[$];
  int         errors = 0;
  int         sent = 0;
  int         gap_pct = 0;

  typedef struct {
    logic       mode;
    logic [4:0] off;
    logic [7:0] data;
    logic       typed;
    logic [7:0] want;
  } row_t;

  float_math_coprocessor u_top (.*);

  always #5 clk = ~clk;

  // Single bits to real
  function automatic real sgl_to_real(input logic [31:0] u);
    logic [63:0] d;
    if (u[30:23] == 8'hFF) begin
      d = (u[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {u[31], 63'h7FF0_0000_0000_0000};
      return $bitstoreal(d);
    end
    if (u[30:23] == 8'h00) return (u[31] ? -1.0 : 1.0) * $itor(u[22:0]) / (2.0 ** 149);
    d = {u[31], 11'(u[30:23] - 127 + 1023), u[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // Real to single bits, round to nearest even; NaN becomes the canonical NaN
  function automatic logic [31:0] real_to_sgl(input real v);
    logic [63:0] d, m53, q, rem, half;
    logic [31:0] sgn;
    int          de, sh;
    d   = $realtobits(v);
    sgn = {d[63], 31'd0};
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : (sgn | 32'h7F80_0000);
    if (d[62:0] == 0) return sgn;
    de  = int'(d[62:52]) - 1023;
    m53 = {11'd0, 1'b1, d[51:0]};
    sh  = (de >= -126) ? 29 : 29 + (-126 - de);
    if (sh > 60) return sgn;
    q    = m53 >> sh;
    rem  = m53 & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (de < -126) return sgn | q[31:0];
    if (de + 127 >= 255) return sgn | 32'h7F80_0000;
    // carry of the significand rolls into the exponent field
    return sgn | ((32'(de + 127 - 1) << 23) + q[31:0]);
  endfunction

  function automatic logic [31:0] operand_value(input logic [31:0] raw, input logic fx);
    if (!fx) return raw;
    return real_to_sgl($itor($signed(raw)) / 4096.0);
  endfunction

  function automatic logic [7:0] class_bits(input logic [31:0] u);
    logic [7:0] r;
    r = '0;
    if (u[30:23] == 8'hFF) r = r | ((u[22:0] != 0) ? ST_NAN : ST_INF);
    if (u[30:0] == 0) r = r | ST_ZERO;
    else if (u[30:23] == 8'h00 || u[30:23] == 8'hFF) r = r | ST_DEN;
    return r;
  endfunction

  function automatic logic [31:0] pick(input logic [1:0] s, input logic [31:0] w0,
                                       input logic [31:0] w1, input logic [31:0] w2,
                                       input logic [31:0] w3);
    case (s)
      2'd0:    return w0;
      2'd1:    return w1;
      2'd2:    return w2;
      default: return w3;
    endcase
  endfunction

  // Compute the byte one read returns from the current shadow registers
  function automatic logic [7:0] coproc_read(input logic [4:0] off);
    logic [31:0] a, b, prod, quo, x, y, sum, res, fixw;
    real         ra, rb, rr, dd;
    logic [7:0]  conv;
    a  = operand_value(sh_opa, sh_ictl[0]);
    b  = operand_value(sh_opb, sh_ictl[1]);
    ra = sgl_to_real(a);
    rb = sgl_to_real(b);
    prod = real_to_sgl(ra * rb);
    if (b[30:0] == 0) begin
      if (class_bits(a) & (ST_NAN | ST_ZERO)) quo = CANON_NAN;
      else quo = {a[31] ^ b[31], 31'h7F80_0000};
    end else begin
      quo = real_to_sgl(ra / rb);
    end
    x   = pick(sh_ictl[5:4], a, b, prod, quo);
    y   = pick(sh_ictl[7:6], a, b, prod, quo);
    sum = real_to_sgl(sh_ictl[3] ? sgl_to_real(x) + sgl_to_real(y)
                                 : sgl_to_real(x) - sgl_to_real(y));
    res = pick(sh_octl[1:0], prod, quo, sum, ONE_BITS);
    rr  = sgl_to_real(res);
    conv = '0;
    if (class_bits(res) & ST_NAN) conv = '0;
    else if (rr == 0.0) conv = ST_ZERO;
    else if (rr > 524287.0 || rr < -524288.0) conv = ST_INF;
    else if (rr > -1.0 / 4096.0 && rr < 1.0 / 4096.0) conv = ST_DEN;
    dd = rr * 4096.0;
    if (class_bits(res) & ST_NAN) fixw = '0;
    else if (dd >= 2147483648.0) fixw = FIX_MAX;
    else if (dd < -2147483648.0) fixw = FIX_MIN;
    else fixw = 32'($rtoi(dd));
    case (off)
      OFF_ST_MUL:  return class_bits(prod);
      OFF_ST_DIV:  return class_bits(quo) | ((b[30:0] == 0) ? ST_DBZ : 8'h00);
      OFF_ST_ADD:  return class_bits(sum);
      OFF_ST_CONV: return conv;
      default: ;
    endcase
    if (off[4:2] == GRP_FLT) return res[8*off[1:0] +: 8];
    if (off[4:2] == GRP_FIX) return fixw[8*off[1:0] +: 8];
    return 8'h00;
  endfunction

  // Apply one transaction to the shadow registers and return the expected byte
  function automatic logic [7:0] coproc_access(input logic m, input logic [4:0] off,
                                               input logic [7:0] v);
    if (m == MODE_READ) begin
      if (off == OFF_CTRL0) return sh_ictl;
      if (off == OFF_CTRL1) return sh_octl;
      return coproc_read(off);
    end
    if (off == OFF_CTRL0) sh_ictl = v;
    else if (off == OFF_CTRL1) sh_octl = v;
    else if (off[4:2] == GRP_OPA) sh_opa[8*off[1:0] +: 8] = v;
    else if (off[4:2] == GRP_OPB) sh_opb[8*off[1:0] +: 8] = v;
    return 8'h00;
  endfunction

  // Issue one transaction; called just after a falling edge, returns after one
  task automatic send(input logic m, input logic [4:0] off, input logic [7:0] v,
                      input logic typed = 1'b0, input logic [7:0] want = '0);
    int         n;
    logic [7:0] pred;
    n = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 8) : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
    start         <= 1'b1;
    in_mode       <= m;
    in_offset     <= off;
    in_write_data <= v;
    do @(posedge clk); while (busy);
    pred = coproc_access(m, off, v);
    exp_bytes.push_back(typed ? want : pred);
    sent++;
    gap_pct = (((sent / 60) % 4) == 1) ? 73 : ((((sent / 60) % 4) == 3) ? 16 : 0);
    @(negedge clk);
  endtask

  // Hold the sender until every pending read has answered
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (exp_bytes.size() != 0);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return $urandom;
      1: return {1'($urandom_range(1)), 31'd0};
      2: return {1'($urandom_range(1)), 31'h7F80_0000};
      3: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
      4: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      5: return {1'($urandom_range(1)), 8'($urandom_range(118, 136)), 23'($urandom)};
      6: return {1'($urandom_range(1)), 8'($urandom_range(1, 20)), 23'($urandom)};
      default: return {1'($urandom_range(1)), 8'($urandom_range(230, 254)), 23'($urandom)};
    endcase
  endfunction

  task automatic load_word(input logic [2:0] grp, input logic [31:0] w);
    for (int i = 0; i < 4; i++) send(MODE_WRITE, {grp, 2'(i)}, w[8*i +: 8]);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_valid) begin
      if (exp_bytes.size() == 0) begin
        $error("read_data: unexpected result 0x%02h", out_read_data);
        errors++;
      end else begin
        want = exp_bytes.pop_front();
        if (out_read_data !== want) begin
          $error("read_data: expected 0x%02h, got 0x%02h", want, out_read_data);
          errors++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    row_t dir[$];
    int   guard;
    sh_ictl = '0; sh_octl = '0; sh_opa = '0; sh_opb = '0;
    // reset values, zero over zero, unmapped and read-only writes, constant one,
    // infinity over zero and its saturated fixed output, infinity plus infinity
    dir = '{
      '{MODE_READ,  OFF_CTRL0,   8'h00, 1'b1, 8'h00},
      '{MODE_READ,  OFF_ST_MUL,  8'h00, 1'b1, 8'h08},
      '{MODE_READ,  OFF_ST_DIV,  8'hFF, 1'b1, 8'h15},
      '{MODE_READ,  OFF_ST_CONV, 8'h00, 1'b1, 8'h08},
      '{MODE_WRITE, 5'd2,        8'hAA, 1'b1, 8'h00},
      '{MODE_READ,  5'd2,        8'h00, 1'b1, 8'h00},
      '{MODE_WRITE, OFF_ST_MUL,  8'hFF, 1'b1, 8'h00},
      '{MODE_WRITE, OFF_CTRL1,   8'h03, 1'b1, 8'h00},
      '{MODE_READ,  5'd16,       8'h00, 1'b1, 8'h00},
      '{MODE_READ,  5'd18,       8'h00, 1'b1, 8'h80},
      '{MODE_READ,  5'd19,       8'h00, 1'b1, 8'h3F},
      '{MODE_READ,  5'd21,       8'h00, 1'b1, 8'h10},
      '{MODE_READ,  OFF_ST_CONV, 8'h00, 1'b1, 8'h00},
      '{MODE_WRITE, 5'd11,       8'h7F, 1'b1, 8'h00},
      '{MODE_WRITE, 5'd10,       8'h80, 1'b1, 8'h00},
      '{MODE_WRITE, OFF_CTRL1,   8'h01, 1'b1, 8'h00},
      '{MODE_READ,  OFF_ST_DIV,  8'h00, 1'b1, 8'h16},
      '{MODE_READ,  OFF_ST_CONV, 8'h00, 1'b1, 8'h02},
      '{MODE_READ,  5'd23,       8'h00, 1'b1, 8'h7F},
      '{MODE_WRITE, OFF_CTRL0,   8'hF8, 1'b1, 8'h00},
      '{MODE_WRITE, OFF_CTRL1,   8'h02, 1'b1, 8'h00},
      '{MODE_READ,  OFF_ST_ADD,  8'h00, 1'b1, 8'h06},
      '{MODE_READ,  OFF_CTRL0,   8'h00, 1'b1, 8'hF8},
      '{MODE_READ,  5'd31,       8'h00, 1'b1, 8'h00},
      '{MODE_WRITE, OFF_CTRL0,   8'h03, 1'b0, 8'h00},
      '{MODE_READ,  5'd20,       8'h00, 1'b0, 8'h00}
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (dir[i]) send(dir[i].mode, dir[i].off, dir[i].data, dir[i].typed, dir[i].want);
    drain();

    // Random part: mostly full setups followed by result reads, some noise
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(99) < 65) begin
        send(MODE_WRITE, OFF_CTRL0, 8'($urandom_range(255)));
        send(MODE_WRITE, OFF_CTRL1, 8'($urandom_range(255)));
        if ($urandom_range(3) != 0) load_word(GRP_OPA, rand_word());
        if ($urandom_range(3) != 0) load_word(GRP_OPB, rand_word());
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(2))
            0: send(MODE_READ, 5'($urandom_range(4, 7)), 8'($urandom_range(255)));
            1: send(MODE_READ, 5'($urandom_range(16, 19)), 8'($urandom_range(255)));
            default: send(MODE_READ, 5'($urandom_range(20, 23)), 8'($urandom_range(255)));
          endcase
        end
      end else begin
        send(1'($urandom_range(1)), 5'($urandom_range(31)), 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 3) drain();
    end

    // Wait out the last reads
    start <= 1'b0;
    guard = 0;
    while (exp_bytes.size() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (60) @(negedge clk);
    if (errors == 0 && exp_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (exp_bytes.size() != 0) $error("read_data: %0d results never arrived", exp_bytes.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/fmc_pkg.sv
rtl/fmc_round.sv
rtl/fmc_divider.sv
rtl/float_math_coprocessor.sv
rtl/fmc_checker.sv
test/tb_top.sv
